>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/core/bcc_pkg.sv
// Package: widths and term helper for the bounded composition counter.
`default_nettype none
package bcc_pkg;
  localparam int unsigned FieldW = 20;
  localparam int unsigned CountW = 58;
  localparam int unsigned NumSub = 16;
  localparam int unsigned SumW   = 23;
  localparam int unsigned AccW   = 64;

  // subset has odd population
  function automatic logic sub_odd(input logic [3:0] s);
    sub_odd = ^s;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/bounded_composition_count_unit.sv
// Top level: bounded composition counter, stream in and out.
// A request passes the stage 0 register, the lane registers, the partial sums and the final sum.
// Throughput: one request per cycle while the output is not stalled; set by
// the lane pipeline (sum, reciprocal divide, two multiplies, add tree).
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module bounded_composition_count_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [19:0] target_sum, [39:20] bound_first, [59:40] bound_second,
  // [79:60] bound_third, [99:80] bound_fourth, [103:100] zero
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [57:0] solution_count, [63:58] zero
  output logic [63:0]       out_tdata
);
  localparam int unsigned Depth = 7;
  logic [Depth-1:0] vld_r, vld_nxt;
  logic en;
  logic [bcc_pkg::FieldW-1:0] m;
  logic [bcc_pkg::SumW-1:0] lim [4];
  logic [bcc_pkg::SumW-1:0] r_r [bcc_pkg::NumSub];
  logic [bcc_pkg::NumSub-1:0] use_r;
  logic [bcc_pkg::AccW-1:0] term [bcc_pkg::NumSub];
  logic [bcc_pkg::AccW-1:0] part_r [4];
  logic [bcc_pkg::AccW-1:0] sum_r;

  // pipeline advances when the last stage is empty or being drained
  assign en        = !vld_r[Depth-1] || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[Depth-2:0], in_tvalid};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage 0: subset sums and compare
  assign m = in_tdata[19:0];
  always_comb begin
    lim[0] = 23'(in_tdata[39:20]) + 23'd1;
    lim[1] = 23'(in_tdata[59:40]) + 23'd1;
    lim[2] = 23'(in_tdata[79:60]) + 23'd1;
    lim[3] = 23'(in_tdata[99:80]) + 23'd1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < bcc_pkg::NumSub; i++) begin
        logic [bcc_pkg::SumW-1:0] s;
        s = (i[0] ? lim[0] : '0) + (i[1] ? lim[1] : '0) +
            (i[2] ? lim[2] : '0) + (i[3] ? lim[3] : '0);
        use_r[i] <= s <= 23'(m);
        r_r[i]   <= 23'(m) - s;
      end
    end
  end

  // stages 1-4: one term lane per subset
  for (genvar g = 0; g < bcc_pkg::NumSub; g++) begin : g_lane
    bcc_term u_term (
      .clk     (clk),
      .en      (en),
      .r_in    (r_r[g]),
      .use_in  (use_r[g]),
      .neg_in  (bcc_pkg::sub_odd(4'(g))),
      .term_out(term[g])
    );
  end

  // stage 5: four partial sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        part_r[k] <= term[4*k] + term[4*k+1] + term[4*k+2] + term[4*k+3];
      end
    end
  end

  // stage 6: final sum
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= part_r[0] + part_r[1] + part_r[2] + part_r[3];
    end
  end

  assign out_tvalid = vld_r[Depth-1];
  assign out_tdata  = {6'd0, sum_r[bcc_pkg::CountW-1:0]};

  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_IMPLIES(a_ready, clk, rst_n, !out_tvalid, in_tready)
  `ASSERT_NEXT(a_flow, clk, rst_n, in_tvalid && in_tready, vld_r[0])
endmodule
`default_nettype wire

>>> rtl/core/bcc_term.sv
// One inclusion-exclusion lane: forms C(r+3,3) over four register stages.
`default_nettype none
module bcc_term (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [bcc_pkg::SumW-1:0] r_in,   // m - s
  input  wire logic                    use_in, // s <= m
  input  wire logic                    neg_in, // odd subset
  output logic [bcc_pkg::AccW-1:0]     term_out
);
  // ceil(2^23 / 3): floor(r * Recip3 / 2^23) == floor(r / 3) for any 23-bit r
  localparam logic [21:0] Recip3 = 22'd2796203;

  logic [44:0] qprod;
  logic [22:0] r1_r;
  logic [21:0] q_r;
  logic        use_r, neg_r, use2_r, neg2_r, use3_r, neg3_r, use4_r, neg4_r;
  logic [1:0]  rem;
  logic [20:0] x_r, y_r;
  logic [19:0] qp_r, qp2_r;
  logic [41:0] xy_r;
  logic [40:0] hi, lo;
  logic [63:0] p_r;
  logic [63:0] h;

  // stage 1: quotient r / 3 by reciprocal multiply
  assign qprod = 45'(r_in) * 45'(Recip3);
  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= r_in;
      q_r   <= qprod[44:23];
      use_r <= use_in;
      neg_r <= neg_in;
    end
  end

  // stage 2: remainder picks the factor divisible by three; that factor / 3 is q+1
  assign rem = 2'(r1_r - (23'(q_r) + {q_r, 1'b0}));
  always_ff @(posedge clk) begin
    if (en) begin
      case (rem)
        2'd1: begin
          x_r <= 21'(r1_r) + 21'd1;
          y_r <= 21'(r1_r) + 21'd3;
        end
        2'd2: begin
          x_r <= 21'(r1_r) + 21'd2;
          y_r <= 21'(r1_r) + 21'd3;
        end
        default: begin
          x_r <= 21'(r1_r) + 21'd1;
          y_r <= 21'(r1_r) + 21'd2;
        end
      endcase
      qp_r   <= 20'(q_r) + 20'd1;
      use2_r <= use_r;
      neg2_r <= neg_r;
    end
  end

  // stage 3: product of the two remaining factors
  always_ff @(posedge clk) begin
    if (en) begin
      xy_r   <= x_r * y_r;
      qp2_r  <= qp_r;
      use3_r <= use2_r;
      neg3_r <= neg2_r;
    end
  end

  // stage 4: times (q+1), split into two 21x20 halves
  assign hi = xy_r[41:21] * qp2_r;
  assign lo = xy_r[20:0] * qp2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= {2'b00, hi, 21'd0} + {23'd0, lo};
      use4_r <= use3_r;
      neg4_r <= neg3_r;
    end
  end

  // product is twice the term and always even
  assign h = {1'b0, p_r[63:1]};
  assign term_out = !use4_r ? '0 : (neg4_r ? (64'd0 - h) : h);
endmodule
`default_nettype wire
